// File: design/tmtc_pkg.sv
// Shared package for the trimmed-mean temperature check unit.
// Holds field widths, register indexes, reset values, status codes and state types.
// No dependencies.
`default_nettype none

package tmtc_pkg;

  // Width of every temperature value in millidegrees.
  localparam int TEMP_W = 18;

  // Width of the reported good-reading count.
  localparam int COUNT_W = 3;

  // Configuration port index width and register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLD = 2'd1;

  // Reset values of the limit registers.
  localparam logic signed [TEMP_W-1:0] HOT_RESET  = 18'sd28000;
  localparam logic signed [TEMP_W-1:0] COLD_RESET = 18'sd23000;

  // Number of quotient bits the divider produces, and its step counter width.
  localparam int QUO_W  = TEMP_W;
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = 5'(QUO_W - 1);

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_HOT  = 2'd1,
    ST_COLD = 2'd2,
    ST_FEW  = 2'd3
  } status_t;

  // Back end sequencer states.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_TRIM = 6'b000010,
    S_ABS  = 6'b000100,
    S_DIV  = 6'b001000,
    S_SIGN = 6'b010000,
    S_CMP  = 6'b100000
  } back_state_t;

endpackage

`default_nettype wire

// File: design/tmtc_front.sv
// Front end: accepts reading attempts and keeps the per-run count, sum, low and high.
// Pushes one run summary into the queue on the last attempt. Uses tmtc_pkg.
`default_nettype none

module tmtc_front #(
  parameter int ATTEMPTS = 5,
  parameter int SW       = 21,
  parameter int GW       = 3
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  input  wire                               q_full,
  input  wire                               reading_ok,
  input  wire logic signed [tmtc_pkg::TEMP_W-1:0] temp_milli,
  output logic                              push,
  output logic signed [SW-1:0]              push_sum,
  output logic signed [tmtc_pkg::TEMP_W-1:0] push_low,
  output logic signed [tmtc_pkg::TEMP_W-1:0] push_high,
  output logic [GW-1:0]                     push_good
);

  localparam int AW = (ATTEMPTS > 1) ? $clog2(ATTEMPTS) : 1;
  localparam int TW = tmtc_pkg::TEMP_W;

  logic [AW-1:0]        attempt;
  logic [GW-1:0]        good;
  logic signed [SW-1:0] sum;
  logic signed [TW-1:0] low;
  logic signed [TW-1:0] high;

  logic [GW-1:0]        good_next;
  logic signed [SW-1:0] sum_next;
  logic signed [TW-1:0] low_next;
  logic signed [TW-1:0] high_next;
  logic                 accept;
  logic                 last;

  assign accept = in_valid && !q_full;
  assign last   = (attempt == AW'(ATTEMPTS - 1));

  // Fold the current reading into the run statistics.
  always_comb begin
    good_next = good;
    sum_next  = sum;
    low_next  = low;
    high_next = high;
    if (reading_ok) begin
      if (good == '0) begin
        low_next  = temp_milli;
        high_next = temp_milli;
      end else begin
        if (temp_milli < low) begin
          low_next = temp_milli;
        end
        if (temp_milli > high) begin
          high_next = temp_milli;
        end
      end
      sum_next  = sum + {{(SW-TW){temp_milli[TW-1]}}, temp_milli};
      good_next = good + 1'b1;
    end
  end

  // Run statistics; cleared at the end of every run.
  always_ff @(posedge clk) begin
    if (rst) begin
      attempt <= '0;
      good    <= '0;
      sum     <= '0;
      low     <= '0;
      high    <= '0;
    end else if (accept) begin
      if (last) begin
        attempt <= '0;
        good    <= '0;
        sum     <= '0;
        low     <= '0;
        high    <= '0;
      end else begin
        attempt <= attempt + 1'b1;
        good    <= good_next;
        sum     <= sum_next;
        low     <= low_next;
        high    <= high_next;
      end
    end
  end

  // The finished run goes to the queue with the last item folded in.
  assign push      = accept && last;
  assign push_sum  = sum_next;
  assign push_low  = low_next;
  assign push_high = high_next;
  assign push_good = good_next;

endmodule

`default_nettype wire

// File: design/tmtc_queue.sv
// Two-entry queue of finished run summaries between the front and back ends.
// Generic over the entry width. No package dependencies.
`default_nettype none

module tmtc_queue #(
  parameter int W = 8
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          push,
  input  wire  [W-1:0] push_data,
  input  wire          pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] entry [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = entry[rd_ptr];

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/tmtc_back.sv
// Back end: trims, divides one quotient bit per cycle, applies the sign and classifies.
// Holds the result in an output register. Uses tmtc_pkg.
`default_nettype none

module tmtc_back #(
  parameter int SW = 21,
  parameter int GW = 3
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                q_empty,
  output logic                               pop,
  input  wire  logic signed [SW-1:0]         q_sum,
  input  wire  logic signed [tmtc_pkg::TEMP_W-1:0] q_low,
  input  wire  logic signed [tmtc_pkg::TEMP_W-1:0] q_high,
  input  wire  [GW-1:0]                      q_good,
  input  wire  logic signed [tmtc_pkg::TEMP_W-1:0] hot_limit,
  input  wire  logic signed [tmtc_pkg::TEMP_W-1:0] cold_limit,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic signed [tmtc_pkg::TEMP_W-1:0] mean_milli,
  output logic [1:0]                         status,
  output logic [tmtc_pkg::COUNT_W-1:0]       good_count
);

  localparam int TEMP_W = tmtc_pkg::TEMP_W;
  localparam int TW     = SW + 1;
  localparam int RW     = GW + 1;
  localparam int QW     = tmtc_pkg::QUO_W;

  tmtc_pkg::back_state_t state;
  tmtc_pkg::back_state_t state_next;

  logic signed [SW-1:0]     e_sum;
  logic signed [TEMP_W-1:0] e_low;
  logic signed [TEMP_W-1:0] e_high;
  logic [GW-1:0]            e_good;
  logic [TW-1:0]            trimmed;
  logic                     neg;
  logic [GW-1:0]            divisor;
  logic [RW-1:0]            rem;
  logic [QW-1:0]            quo;
  logic [tmtc_pkg::STEP_W-1:0] step;
  logic signed [TEMP_W-1:0] mean;
  logic                     few;

  logic [TW-1:0]            mag;
  logic [RW-1:0]            shifted;
  logic                     qbit;
  logic                     out_free;
  tmtc_pkg::status_t        class_code;

  assign few      = (e_good <= GW'(2));
  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == tmtc_pkg::S_IDLE) && !q_empty;

  // Magnitude of the trimmed sum and one restoring division step.
  assign mag     = trimmed[TW-1] ? (~trimmed + 1'b1) : trimmed;
  assign shifted = {rem[RW-2:0], quo[QW-1]};
  assign qbit    = (shifted >= {1'b0, divisor});

  // Classification of the finished mean; the too-few test wins, then the hot test.
  always_comb begin
    if (few) begin
      class_code = tmtc_pkg::ST_FEW;
    end else if (mean > hot_limit) begin
      class_code = tmtc_pkg::ST_HOT;
    end else if (mean < cold_limit) begin
      class_code = tmtc_pkg::ST_COLD;
    end else begin
      class_code = tmtc_pkg::ST_OK;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      tmtc_pkg::S_IDLE: begin
        if (!q_empty) begin
          state_next = tmtc_pkg::S_TRIM;
        end
      end
      tmtc_pkg::S_TRIM: state_next = few ? tmtc_pkg::S_CMP : tmtc_pkg::S_ABS;
      tmtc_pkg::S_ABS:  state_next = tmtc_pkg::S_DIV;
      tmtc_pkg::S_DIV: begin
        if (step == tmtc_pkg::LAST_STEP) begin
          state_next = tmtc_pkg::S_SIGN;
        end
      end
      tmtc_pkg::S_SIGN: state_next = tmtc_pkg::S_CMP;
      tmtc_pkg::S_CMP: begin
        if (out_free) begin
          state_next = tmtc_pkg::S_IDLE;
        end
      end
      default: state_next = tmtc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmtc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      tmtc_pkg::S_IDLE: begin
        e_sum  <= q_sum;
        e_low  <= q_low;
        e_high <= q_high;
        e_good <= q_good;
      end
      tmtc_pkg::S_TRIM: begin
        trimmed <= {{(TW-SW){e_sum[SW-1]}}, e_sum}
                 - {{(TW-TEMP_W){e_low[TEMP_W-1]}}, e_low}
                 - {{(TW-TEMP_W){e_high[TEMP_W-1]}}, e_high};
        mean    <= '0;
      end
      tmtc_pkg::S_ABS: begin
        neg     <= trimmed[TW-1];
        rem     <= RW'(mag[TW-1:QW]);
        quo     <= mag[QW-1:0];
        divisor <= e_good - GW'(2);
        step    <= '0;
      end
      tmtc_pkg::S_DIV: begin
        if (qbit) begin
          rem <= shifted - {1'b0, divisor};
        end else begin
          rem <= shifted;
        end
        quo  <= {quo[QW-2:0], qbit};
        step <= step + 1'b1;
      end
      tmtc_pkg::S_SIGN: begin
        mean <= neg ? $signed(~quo + 1'b1) : $signed(quo);
      end
      default: begin
      end
    endcase
  end

  // Output register: loads when free, otherwise clears once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == tmtc_pkg::S_CMP) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == tmtc_pkg::S_CMP) && out_free) begin
      mean_milli <= mean;
      status     <= class_code;
      good_count <= tmtc_pkg::COUNT_W'(e_good);
    end
  end

  // The divider only runs on runs with a nonzero trimmed divisor.
  a_div_has_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == tmtc_pkg::S_DIV) |-> (divisor != '0))
    else $error("divider running with a zero divisor");

  // The partial remainder always stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == tmtc_pkg::S_DIV) |-> (rem < {1'b0, divisor}))
    else $error("partial remainder reached the divisor");

  // A too-few result carries a zero mean.
  a_few_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == tmtc_pkg::ST_FEW)) |-> (mean_milli == '0))
    else $error("too-few result with a nonzero mean");

  // A new result only appears from the classify step.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == tmtc_pkg::S_CMP))
    else $error("result appeared outside the classify step");

endmodule

`default_nettype wire

// File: design/trimmed_mean_temperature_check_unit.sv
// Top level of the trimmed-mean temperature check unit; uses tmtc_pkg and the front,
// queue and back modules. A run's result comes from the one-bit-per-cycle divider that
// produces 18 quotient bits; when two or fewer readings were good, the division is skipped.
// Items enter the front end at one item per cycle while the queue is not full; the back
// end takes a new run from the queue only once the last one has left the classify step.
// Reset (rst, synchronous) clears runs, queue and sequencer.
`default_nettype none

module trimmed_mean_temperature_check_unit #(
  parameter int ATTEMPTS = 5
) (
  input  wire                                      clk,
  input  wire                                      rst,
  input  wire                                      cfg_we,
  input  wire  [tmtc_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire  [tmtc_pkg::TEMP_W-1:0]              cfg_data,
  input  wire                                      in_valid,
  output logic                                     in_stall,
  input  wire                                      reading_ok,
  input  wire  logic signed [tmtc_pkg::TEMP_W-1:0] temp_milli,
  output logic                                     out_valid,
  input  wire                                      out_stall,
  output logic signed [tmtc_pkg::TEMP_W-1:0]       mean_milli,
  output logic [1:0]                               status,
  output logic [tmtc_pkg::COUNT_W-1:0]             good_count
);

  localparam int TEMP_W = tmtc_pkg::TEMP_W;
  localparam int SW     = TEMP_W + $clog2(ATTEMPTS);
  localparam int GW     = $clog2(ATTEMPTS + 1);
  localparam int QEW    = SW + 2 * TEMP_W + GW;

  logic signed [TEMP_W-1:0] hot_limit;
  logic signed [TEMP_W-1:0] cold_limit;

  logic                     push;
  logic signed [SW-1:0]     push_sum;
  logic signed [TEMP_W-1:0] push_low;
  logic signed [TEMP_W-1:0] push_high;
  logic [GW-1:0]            push_good;
  logic                     pop;
  logic [QEW-1:0]           pop_data;
  logic                     q_full;
  logic                     q_empty;

  // Limit registers; they return to 28000 and 23000 millidegrees at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      hot_limit  <= tmtc_pkg::HOT_RESET;
      cold_limit <= tmtc_pkg::COLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tmtc_pkg::CFG_HOT:  hot_limit  <= $signed(cfg_data);
        tmtc_pkg::CFG_COLD: cold_limit <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Items wait whenever the queue has no room for another run.
  assign in_stall = q_full;

  tmtc_front #(
    .ATTEMPTS (ATTEMPTS),
    .SW       (SW),
    .GW       (GW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .q_full     (q_full),
    .reading_ok (reading_ok),
    .temp_milli (temp_milli),
    .push       (push),
    .push_sum   (push_sum),
    .push_low   (push_low),
    .push_high  (push_high),
    .push_good  (push_good)
  );

  tmtc_queue #(
    .W (QEW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_sum, push_low, push_high, push_good}),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  tmtc_back #(
    .SW (SW),
    .GW (GW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .pop        (pop),
    .q_sum      ($signed(pop_data[QEW-1 -: SW])),
    .q_low      ($signed(pop_data[GW+2*TEMP_W-1 -: TEMP_W])),
    .q_high     ($signed(pop_data[GW+TEMP_W-1 -: TEMP_W])),
    .q_good     (pop_data[GW-1:0]),
    .hot_limit  (hot_limit),
    .cold_limit (cold_limit),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .mean_milli (mean_milli),
    .status     (status),
    .good_count (good_count)
  );

endmodule

`default_nettype wire
